@@ design/double_ended_queue_assert.svh @@
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk_i, off during reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, off during reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg)
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/deq_pkg.sv @@
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

  localparam int DefaultCapacity = 16;
  localparam int WordW           = 32;
  localparam int CountW          = 5;

  typedef enum logic [1:0] {
    CmdPushFront = 2'd0,
    CmdPushBack  = 2'd1,
    CmdPopFront  = 2'd2,
    CmdPopBack   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [WordW-1:0] value_in;
  } deq_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] value_out;
    status_e                 status;
    logic [CountW-1:0]       count;
    logic                    full_res;
  } deq_out_t;

  // per-chain control, same for every cell of the chain
  typedef struct packed {
    logic push_head;
    logic pop_head;
    logic put_tail;
  } chain_ctrl_t;

endpackage

`default_nettype wire

@@ design/deq_cell.sv @@
// one storage cell of a head-justified word chain
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity,
  parameter int INDEX    = 0
) (
  input  wire                          clk_i,
  input  wire chain_ctrl_t             ctrl_i,
  input  wire [$clog2(CAPACITY)-1:0]   wr_idx_i,
  input  wire  logic signed [WordW-1:0] value_i,
  input  wire  logic signed [WordW-1:0] lower_i,
  input  wire  logic signed [WordW-1:0] upper_i,
  output logic signed [WordW-1:0]      data_o
);

  localparam int IdxW = $clog2(CAPACITY);

  logic signed [WordW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_head) begin
      data_d = lower_i;
    end else if (ctrl_i.pop_head) begin
      data_d = upper_i;
    end else if (ctrl_i.put_tail && (wr_idx_i == IdxW'(INDEX))) begin
      data_d = value_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ design/deq_chain.sv @@
// row of cells holding the queue with one end fixed at cell zero
`default_nettype none

module deq_chain
  import deq_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity
) (
  input  wire                           clk_i,
  input  wire chain_ctrl_t              ctrl_i,
  input  wire [$clog2(CAPACITY)-1:0]    wr_idx_i,
  input  wire  logic signed [WordW-1:0] value_i,
  output logic signed [WordW-1:0]       head_o
);

  logic signed [WordW-1:0] cell_data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WordW-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = value_i;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    deq_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .wr_idx_i (wr_idx_i),
      .value_i  (value_i),
      .lower_i  (lower),
      .upper_i  (upper),
      .data_o   (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

`default_nettype wire

@@ design/double_ended_queue.sv @@
// top level of the fixed-capacity double-ended queue
//
// usage:
//   a command word (push front, push back, pop front, pop back plus the
//   word to push) is taken on item_i at a rising edge with start high and
//   busy low. busy stays low, so a new command can be issued every cycle.
//   every command gives exactly one result word on res_o, marked by done_o
//   for one cycle, the cycle right after the command was taken; throughput
//   is one word per cycle.
//   result: popped word (zero for pushes and failed pops), status, count
//   after the command and a full flag. a push when full is dropped, a pop
//   when empty returns zero with the empty status.
//   the receiver cannot stall: results are shown for one cycle only.
//   reset clears the occupancy count and the result strobe; cell contents
//   are not reset and are never read before being written.
//   storage is two mirrored cell chains with the same contents: one keeps
//   the front word at its cell zero, the other keeps the back word there.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start,
  output logic         busy,
  input  wire deq_in_t item_i,
  output logic         done_o,
  output deq_out_t     res_o
);

  `include "double_ended_queue_assert.svh"

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  logic                    accept;
  logic [CntW-1:0]         count_d, count_q;
  logic                    is_full, is_empty;
  chain_ctrl_t             ctrl_front, ctrl_back;
  logic [IdxW-1:0]         tail_idx;
  logic signed [WordW-1:0] head_front, head_back;
  deq_out_t                res_d, res_q;
  logic                    done_q;

  // one command per cycle, never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);
  // only used on pushes, where count is below capacity and fits the index
  assign tail_idx = count_q[IdxW-1:0];

  // command decode: the pushed end shifts its chain, the other chain just
  // drops the word in at the first free cell; a pop shifts only its own chain
  always_comb begin
    ctrl_front      = '0;
    ctrl_back       = '0;
    count_d         = count_q;
    res_d.value_out = '0;
    res_d.status    = StDone;
    if (accept) begin
      unique case (item_i.command)
        CmdPushFront: begin
          if (is_full) begin
            res_d.status = StFull;
          end else begin
            ctrl_front.push_head = 1'b1;
            ctrl_back.put_tail   = 1'b1;
            count_d              = count_q + CntW'(1);
          end
        end
        CmdPushBack: begin
          if (is_full) begin
            res_d.status = StFull;
          end else begin
            ctrl_back.push_head = 1'b1;
            ctrl_front.put_tail = 1'b1;
            count_d             = count_q + CntW'(1);
          end
        end
        CmdPopFront: begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else begin
            ctrl_front.pop_head = 1'b1;
            res_d.value_out     = head_front;
            count_d             = count_q - CntW'(1);
          end
        end
        CmdPopBack: begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else begin
            ctrl_back.pop_head = 1'b1;
            res_d.value_out    = head_back;
            count_d            = count_q - CntW'(1);
          end
        end
        default: begin
          res_d.status = StDone;
        end
      endcase
    end
    // count field is reported modulo its port width
    res_d.count    = CountW'(count_d);
    res_d.full_res = (count_d == CntW'(CAPACITY));
  end

  // chain with the front word at cell zero
  deq_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain_front (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl_front),
    .wr_idx_i (tail_idx),
    .value_i  (item_i.value_in),
    .head_o   (head_front)
  );

  // chain with the back word at cell zero
  deq_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain_back (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl_back),
    .wr_idx_i (tail_idx),
    .value_i  (item_i.value_in),
    .head_o   (head_back)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // assertions
  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "occupancy above capacity")
  `DEQ_ASSERT_NEXT(a_one_result, accept, done_o, "accepted command gave no result")
  `DEQ_ASSERT_NEXT(a_no_spurious, !accept, !done_o, "result without a command")
  `DEQ_ASSERT_NEXT(a_full_drop, accept && is_full && (item_i.command == CmdPushFront || item_i.command == CmdPushBack), res_o.status == StFull && $stable(count_q), "push when full not dropped")

endmodule

`default_nettype wire
